@@ hdl/cdq_pkg.sv @@
// Shared types and constants for the circular deque unit.
// Depends on nothing; every other file of the block imports it.
package cdq_pkg;

	localparam int DATA_W = 32;
	localparam int CNT_W  = 5;
	localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

	typedef enum logic [1:0] {
		OP_PUSH_FRONT = 2'd0,
		OP_PUSH_REAR  = 2'd1,
		OP_POP_FRONT  = 2'd2,
		OP_POP_REAR   = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		opcode_t                   opcode;
		logic signed [DATA_W-1:0]  push_value;
	} req_t;

	typedef struct packed {
		status_t                   status;
		logic signed [DATA_W-1:0]  pop_value;
		logic [CNT_W-1:0]          occupancy;
	} rsp_t;

	typedef struct packed {
		status_t           status;
		logic [CNT_W-1:0]  occupancy;
		logic              pop_ok;
	} res_t;

endpackage

@@ hdl/cdq_ram.sv @@
// Single-port ring store of the circular deque with a registered read.
// Depends on cdq_pkg for the data width.
module cdq_ram
	import cdq_pkg::*;
#(
	parameter int DEPTH = 16,
	parameter int IW    = 4
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [IW-1:0]            addr,
	input  logic signed [DATA_W-1:0] wdata,
	output logic signed [DATA_W-1:0] rdata
);

	logic signed [DATA_W-1:0] mem [DEPTH];
	logic signed [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ hdl/cdq_ctrl.sv @@
// Front, rear and count registers of the circular deque and the store access they issue.
// Depends on cdq_pkg for opcodes, status codes and the result struct.
module cdq_ctrl
	import cdq_pkg::*;
#(
	parameter int DEPTH = 16,
	parameter int IW    = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             acc,
	input  opcode_t          opcode,
	input  logic [CNT_W-1:0] capacity,
	output logic             mem_we,
	output logic             mem_re,
	output logic [IW-1:0]    mem_addr,
	output res_t             res
);

	localparam int CW = (IW > CNT_W) ? IW : CNT_W;
	localparam logic [CNT_W-1:0] DEPTH_CAP = (DEPTH > 31) ? 5'd31 : CNT_W'(DEPTH);

	logic [IW-1:0]    front_q, rear_q, front_d, rear_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W-1:0] cap_eff;
	logic             full, empty;

	function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] idx,
			input logic [CNT_W-1:0] cap);
		logic [CW-1:0] i;
		logic [CW-1:0] c;
		i = CW'(idx);
		c = CW'(cap) - CW'(1);
		return (i >= c) ? '0 : idx + IW'(1);
	endfunction

	function automatic logic [IW-1:0] wrap_dec(input logic [IW-1:0] idx,
			input logic [CNT_W-1:0] cap);
		logic [CW-1:0] c;
		c = CW'(cap) - CW'(1);
		return (idx == '0) ? IW'(c) : idx - IW'(1);
	endfunction

	always_comb begin
		if (capacity == '0) begin
			cap_eff = CNT_W'(1);
		end else if (capacity > DEPTH_CAP) begin
			cap_eff = DEPTH_CAP;
		end else begin
			cap_eff = capacity;
		end
	end

	assign full  = (count_q >= cap_eff);
	assign empty = (count_q == '0);

	always_comb begin
		front_d    = front_q;
		rear_d     = rear_q;
		count_d    = count_q;
		mem_we     = 1'b0;
		mem_re     = 1'b0;
		mem_addr   = '0;
		res.status = ST_OK;
		res.pop_ok = 1'b0;
		case (opcode)
			OP_PUSH_FRONT, OP_PUSH_REAR: begin
				if (full) begin
					res.status = ST_FULL;
				end else begin
					mem_we  = acc;
					count_d = count_q + CNT_W'(1);
					if (empty) begin
						front_d  = '0;
						rear_d   = '0;
						mem_addr = '0;
					end else if (opcode == OP_PUSH_FRONT) begin
						front_d  = wrap_dec(front_q, cap_eff);
						mem_addr = front_d;
					end else begin
						rear_d   = wrap_inc(rear_q, cap_eff);
						mem_addr = rear_d;
					end
				end
			end
			OP_POP_FRONT, OP_POP_REAR: begin
				if (empty) begin
					res.status = ST_EMPTY;
				end else begin
					mem_re     = acc;
					res.pop_ok = 1'b1;
					count_d    = count_q - CNT_W'(1);
					mem_addr   = (opcode == OP_POP_FRONT) ? front_q : rear_q;
					if (count_d == '0) begin
						front_d = '0;
						rear_d  = '0;
					end else if (opcode == OP_POP_FRONT) begin
						front_d = wrap_inc(front_q, cap_eff);
					end else begin
						rear_d = wrap_dec(rear_q, cap_eff);
					end
				end
			end
			default: begin
				res.status = ST_OK;
			end
		endcase
		res.occupancy = count_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			rear_q  <= '0;
			count_q <= '0;
		end else if (acc) begin
			front_q <= front_d;
			rear_q  <= rear_d;
			count_q <= count_d;
		end
	end

`ifndef SYNTH
	// An empty deque always has both indices parked on slot zero.
	a_empty_parked: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (front_q == '0 && rear_q == '0))
		else $error("empty deque with indices off slot zero");

	a_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({mem_we, mem_re}) <= 1)
		else $error("store written and read in the same cycle");

	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!acc |=> ($stable(count_q) && $stable(front_q) && $stable(rear_q)))
		else $error("deque state changed without an accepted beat");
`endif

endmodule

@@ hdl/circular_deque_unit.sv @@
// Top level of the circular deque unit: capacity register, control, ring store, result stage.
// Depends on cdq_pkg, cdq_ctrl and cdq_ram.
//
// The unit takes one request beat per clock and returns one response beat for each, in the
// cycle after the request is accepted. Index and count updates finish in the cycle of
// acceptance, and a pop's value comes from the ring store's registered read port into the
// response stage, so a pop may directly follow a push to the same slot. Requests stall only
// while the response stage holds a beat that the receiver is stalling. The ring store is
// not cleared at reset; entries are written before they are read while capacity is unchanged.
module circular_deque_unit
	import cdq_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [CNT_W-1:0] cfg_wr_data,
	input  logic             req_valid,
	output logic             req_stall,
	input  req_t             req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output rsp_t             rsp
);

	localparam int IW = $clog2(DEPTH);

	logic [CNT_W-1:0]         capacity_q;
	logic                     acc;
	logic                     mem_we, mem_re;
	logic [IW-1:0]            mem_addr;
	logic signed [DATA_W-1:0] rdata;
	res_t                     res;
	res_t                     res_s1;
	logic                     valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_wr_en) begin
			capacity_q <= cfg_wr_data;
		end
	end

	assign req_stall = valid_s1 && rsp_stall;
	assign acc       = req_valid && !req_stall;

	cdq_ctrl #(
		.DEPTH (DEPTH),
		.IW    (IW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.acc      (acc),
		.opcode   (req.opcode),
		.capacity (capacity_q),
		.mem_we   (mem_we),
		.mem_re   (mem_re),
		.mem_addr (mem_addr),
		.res      (res)
	);

	cdq_ram #(
		.DEPTH (DEPTH),
		.IW    (IW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.re    (mem_re),
		.addr  (mem_addr),
		.wdata (req.push_value),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc) begin
			valid_s1 <= 1'b1;
		end else if (!rsp_stall) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			res_s1 <= res;
		end
	end

	assign rsp_valid     = valid_s1;
	assign rsp.status    = res_s1.status;
	assign rsp.occupancy = res_s1.occupancy;
	assign rsp.pop_value = res_s1.pop_ok ? rdata : '0;

endmodule
